### rtl/pcsc_pkg.sv
// Shared types, constants and the CRC-32 byte step for the PNG chunk stream checker.
// No dependencies; every other file imports this package.
package pcsc_pkg;

	localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
	localparam logic [31:0] TYPE_IHDR = 32'h49484452;
	localparam logic [31:0] TYPE_IDAT = 32'h49444154;
	localparam logic [31:0] TYPE_IEND = 32'h49454E44;
	localparam logic [31:0] IHDR_MIN_LEN = 32'd13;
	localparam logic [32:0] TRUNC_MIN_BYTES = 33'd12;

	typedef enum logic [2:0] {
		PH_SIG  = 3'd0,
		PH_LEN  = 3'd1,
		PH_TYPE = 3'd2,
		PH_DATA = 3'd3,
		PH_CRC  = 3'd4,
		PH_STOP = 3'd5
	} phase_t;

	typedef struct packed {
		logic stop_sig;
		logic crc_bad;
		logic sig_bad;
		logic any;
		logic first;
		logic iend;
		logic idat;
		logic ihdr;
	} seen_t;

	// One entry per byte that yields results: a chunk record, a summary, or both.
	typedef struct packed {
		logic        has_chunk;
		logic        has_sum;
		logic [31:0] ctype;
		logic [31:0] clen;
		logic        match;
		logic [31:0] width;
		logic [31:0] height;
		logic [7:0]  depth;
		logic [7:0]  colour;
		logic [15:0] count;
		logic [7:0]  flags;
		logic [31:0] trail;
	} rec_t;

	function automatic logic [7:0] sig_byte(input logic [2:0] i);
		logic [7:0] v;
		case (i)
			3'd0: v = 8'h89;
			3'd1: v = 8'h50;
			3'd2: v = 8'h4E;
			3'd3: v = 8'h47;
			3'd4: v = 8'h0D;
			3'd5: v = 8'h0A;
			3'd6: v = 8'h1A;
			3'd7: v = 8'h0A;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	// Reflected CRC-32, one byte: eight shift/xor steps.
	function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? (CRC_POLY ^ (r >> 1)) : (r >> 1);
		end
		return r;
	endfunction

endpackage

### rtl/png_chunk_stream_checker_core.sv
// Top level of the PNG chunk stream checker: walker, result queue, output stage.
// Depends on pcsc_pkg, pcsc_walker, pcsc_queue and pcsc_emitter.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_ready  | data_byte, end_of_file
//  out     | out_valid / out_ready| record_kind .. trailing_count, last_of_run
//
// One byte is taken per cycle whenever the result queue (QDEPTH entries) has room.
// Each byte updates the walker counters and phase; type and data bytes also step the CRC.
// A byte that ends a chunk and the file yields two results, sent as two output transfers.
// Results pass through the queue and the emitter's entry register to reach the port.
// Reset is asynchronous, clearing all but stored entries; end of file resets the walker.
// A stalled output fills the queue, and in_ready drops once it is full.
module png_chunk_stream_checker_core
	import pcsc_pkg::*;
#(
	parameter int QDEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_file,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        record_kind,
	output logic [31:0] chunk_type,
	output logic [31:0] chunk_length,
	output logic        crc_match,
	output logic [31:0] image_width,
	output logic [31:0] image_height,
	output logic [7:0]  bit_depth,
	output logic [7:0]  colour_type,
	output logic [15:0] chunks_seen,
	output logic [7:0]  error_flags,
	output logic [31:0] trailing_count,
	output logic        last_of_run
);

	logic q_full;
	logic q_push;
	rec_t q_push_rec;
	logic q_pop;
	rec_t q_pop_rec;
	logic q_nonempty;

	pcsc_walker u_walker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.end_of_file (end_of_file),
		.q_full      (q_full),
		.push        (q_push),
		.push_rec    (q_push_rec)
	);

	pcsc_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_rec (q_push_rec),
		.full     (q_full),
		.pop      (q_pop),
		.pop_rec  (q_pop_rec),
		.nonempty (q_nonempty)
	);

	pcsc_emitter u_emitter (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_nonempty     (q_nonempty),
		.q_rec          (q_pop_rec),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.record_kind    (record_kind),
		.chunk_type     (chunk_type),
		.chunk_length   (chunk_length),
		.crc_match      (crc_match),
		.image_width    (image_width),
		.image_height   (image_height),
		.bit_depth      (bit_depth),
		.colour_type    (colour_type),
		.chunks_seen    (chunks_seen),
		.error_flags    (error_flags),
		.trailing_count (trailing_count),
		.last_of_run    (last_of_run)
	);

endmodule

### rtl/pcsc_walker.sv
// Front end: takes file bytes, checks the signature, walks chunks and the CRC,
// and builds result entries for the queue. Depends on pcsc_pkg.
module pcsc_walker
	import pcsc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_file,
	input  logic        q_full,
	output logic        push,
	output rec_t        push_rec
);

	phase_t      phase_q, phase_n;
	logic [31:0] idx_q, idx_n;
	logic [31:0] len_q, len_n;
	logic [31:0] type_q, type_n;
	logic [31:0] crc_q, crc_n;
	logic [31:0] stored_q, stored_n;
	logic [31:0] cap_w_q, cap_w_n;
	logic [31:0] cap_h_q, cap_h_n;
	logic [15:0] cap_dc_q, cap_dc_n;
	logic [15:0] cnt_q, cnt_n;
	seen_t       seen_q, seen_n;
	logic [31:0] trail_q, trail_n;
	logic [32:0] cbytes_q, cbytes_n;
	logic [31:0] pend_w_q, pend_w_n;
	logic [31:0] pend_h_q, pend_h_n;
	logic [15:0] pend_dc_q, pend_dc_n;

	logic        accept;
	logic        crc_last;
	logic        match;
	logic        sig_err;
	logic [31:0] idx_inc;
	logic        walking;
	logic [31:0] trail_sum;
	rec_t        rec;

	assign in_ready = !q_full;
	assign accept   = in_valid && !q_full;
	assign idx_inc  = idx_q + 32'd1;
	assign crc_last = (phase_q == PH_CRC) && (idx_q[1:0] == 2'd3);
	assign match    = ({stored_q[23:0], data_byte} == ~crc_q);
	assign sig_err  = (data_byte != sig_byte(idx_q[2:0]));

	// next phase
	always_comb begin
		phase_n = phase_q;
		case (phase_q)
			PH_SIG: begin
				if (idx_q[2:0] == 3'd7) begin
					phase_n = (seen_q.sig_bad || sig_err) ? PH_STOP : PH_LEN;
				end
			end
			PH_LEN: begin
				if (idx_q[1:0] == 2'd3) begin
					phase_n = PH_TYPE;
				end
			end
			PH_TYPE: begin
				if (idx_q[1:0] == 2'd3) begin
					phase_n = (len_q == 32'd0) ? PH_CRC : PH_DATA;
				end
			end
			PH_DATA: begin
				if (idx_inc == len_q) begin
					phase_n = PH_CRC;
				end
			end
			PH_CRC: begin
				if (crc_last) begin
					phase_n = match ? PH_LEN : PH_STOP;
				end
			end
			PH_STOP: phase_n = PH_STOP;
			default: phase_n = PH_STOP;
		endcase
	end

	// datapath and result entry
	always_comb begin
		idx_n     = idx_q;
		len_n     = len_q;
		type_n    = type_q;
		crc_n     = crc_q;
		stored_n  = stored_q;
		cap_w_n   = cap_w_q;
		cap_h_n   = cap_h_q;
		cap_dc_n  = cap_dc_q;
		cnt_n     = cnt_q;
		seen_n    = seen_q;
		trail_n   = trail_q;
		cbytes_n  = cbytes_q;
		pend_w_n  = pend_w_q;
		pend_h_n  = pend_h_q;
		pend_dc_n = pend_dc_q;
		rec       = '0;

		case (phase_q)
			PH_SIG: begin
				if (sig_err) begin
					seen_n.sig_bad = 1'b1;
				end
				if (idx_q[2:0] == 3'd7) begin
					idx_n = 32'd0;
					if (seen_n.sig_bad) begin
						seen_n.stop_sig = 1'b1;
					end
				end else begin
					idx_n = idx_inc;
				end
			end
			PH_LEN: begin
				len_n    = {len_q[23:0], data_byte};
				cbytes_n = cbytes_q + 33'd1;
				if (idx_q[1:0] == 2'd3) begin
					idx_n = 32'd0;
					crc_n = CRC_INIT;
				end else begin
					idx_n = idx_inc;
				end
			end
			PH_TYPE: begin
				type_n   = {type_q[23:0], data_byte};
				crc_n    = crc32_byte(crc_q, data_byte);
				cbytes_n = cbytes_q + 33'd1;
				idx_n    = (idx_q[1:0] == 2'd3) ? 32'd0 : idx_inc;
			end
			PH_DATA: begin
				crc_n    = crc32_byte(crc_q, data_byte);
				cbytes_n = cbytes_q + 33'd1;
				if (idx_q < 32'd4) begin
					pend_w_n = {pend_w_q[23:0], data_byte};
				end else if (idx_q < 32'd8) begin
					pend_h_n = {pend_h_q[23:0], data_byte};
				end else if (idx_q < 32'd10) begin
					pend_dc_n = {pend_dc_q[7:0], data_byte};
				end
				idx_n = (idx_inc == len_q) ? 32'd0 : idx_inc;
			end
			PH_CRC: begin
				stored_n = {stored_q[23:0], data_byte};
				cbytes_n = cbytes_q + 33'd1;
				idx_n    = idx_inc;
				if (crc_last) begin
					if (cnt_q != 16'hFFFF) begin
						cnt_n = cnt_q + 16'd1;
					end
					if (!seen_q.any && type_q == TYPE_IHDR) begin
						seen_n.first = 1'b1;
					end
					seen_n.any = 1'b1;
					if (type_q == TYPE_IHDR) begin
						seen_n.ihdr = 1'b1;
						if (len_q >= IHDR_MIN_LEN) begin
							cap_w_n  = pend_w_q;
							cap_h_n  = pend_h_q;
							cap_dc_n = pend_dc_q;
						end
					end else if (type_q == TYPE_IDAT) begin
						seen_n.idat = 1'b1;
					end else if (type_q == TYPE_IEND) begin
						seen_n.iend = 1'b1;
					end
					if (!match) begin
						seen_n.crc_bad = 1'b1;
					end
					rec.has_chunk = 1'b1;
					rec.ctype     = type_q;
					rec.clen      = len_q;
					rec.match     = match;
					idx_n    = 32'd0;
					len_n    = 32'd0;
					type_n   = 32'd0;
					stored_n = 32'd0;
					cbytes_n = 33'd0;
				end
			end
			PH_STOP: begin
				if (trail_q != 32'hFFFFFFFF) begin
					trail_n = trail_q + 32'd1;
				end
			end
			default: begin
				trail_n = trail_q;
			end
		endcase

		rec.count = cnt_n;

		// A partial chunk at end of file counts as trailing; trail_q is still zero then.
		walking   = (phase_n == PH_LEN) || (phase_n == PH_TYPE) ||
			(phase_n == PH_DATA) || (phase_n == PH_CRC);
		trail_sum = walking ? (cbytes_n[32] ? 32'hFFFFFFFF : cbytes_n[31:0]) : trail_n;

		if (end_of_file) begin
			rec.has_sum  = 1'b1;
			rec.width    = cap_w_n;
			rec.height   = cap_h_n;
			rec.depth    = cap_dc_n[15:8];
			rec.colour   = cap_dc_n[7:0];
			rec.trail    = trail_sum;
			rec.flags[0] = (phase_n == PH_SIG) || seen_n.stop_sig;
			rec.flags[1] = seen_n.crc_bad;
			rec.flags[2] = walking && (cbytes_n >= TRUNC_MIN_BYTES);
			rec.flags[3] = !seen_n.first;
			rec.flags[4] = !seen_n.ihdr;
			rec.flags[5] = !seen_n.idat;
			rec.flags[6] = !seen_n.iend;
			rec.flags[7] = (trail_sum != 32'd0);
		end
	end

	assign push     = accept && (rec.has_chunk || rec.has_sum);
	assign push_rec = rec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SIG;
			idx_q     <= '0;
			len_q     <= '0;
			type_q    <= '0;
			crc_q     <= CRC_INIT;
			stored_q  <= '0;
			cap_w_q   <= '0;
			cap_h_q   <= '0;
			cap_dc_q  <= '0;
			cnt_q     <= '0;
			seen_q    <= '0;
			trail_q   <= '0;
			cbytes_q  <= '0;
			pend_w_q  <= '0;
			pend_h_q  <= '0;
			pend_dc_q <= '0;
		end else if (accept) begin
			if (end_of_file) begin
				// start over: the next byte opens a new file
				phase_q   <= PH_SIG;
				idx_q     <= '0;
				len_q     <= '0;
				type_q    <= '0;
				crc_q     <= CRC_INIT;
				stored_q  <= '0;
				cap_w_q   <= '0;
				cap_h_q   <= '0;
				cap_dc_q  <= '0;
				cnt_q     <= '0;
				seen_q    <= '0;
				trail_q   <= '0;
				cbytes_q  <= '0;
				pend_w_q  <= '0;
				pend_h_q  <= '0;
				pend_dc_q <= '0;
			end else begin
				phase_q   <= phase_n;
				idx_q     <= idx_n;
				len_q     <= len_n;
				type_q    <= type_n;
				crc_q     <= crc_n;
				stored_q  <= stored_n;
				cap_w_q   <= cap_w_n;
				cap_h_q   <= cap_h_n;
				cap_dc_q  <= cap_dc_n;
				cnt_q     <= cnt_n;
				seen_q    <= seen_n;
				trail_q   <= trail_n;
				cbytes_q  <= cbytes_n;
				pend_w_q  <= pend_w_n;
				pend_h_q  <= pend_h_n;
				pend_dc_q <= pend_dc_n;
			end
		end
	end

endmodule

### rtl/pcsc_queue.sv
// Short FIFO of result entries between the chunk walker and the output stage.
// Depends on pcsc_pkg for the entry type.
module pcsc_queue
	import pcsc_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rec_t push_rec,
	output logic full,
	input  logic pop,
	output rec_t pop_rec,
	output logic nonempty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	rec_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full     = (cnt_q == CW'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign pop_rec  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty) else $error("queue read while empty");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH)) else $error("queue fill count out of range");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q)) else $error("empty queue with pointer gap");

endmodule

### rtl/pcsc_emitter.sv
// Back end: takes entries from the queue and presents their chunk record and
// summary one transfer at a time. Depends on pcsc_pkg.
module pcsc_emitter
	import pcsc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_nonempty,
	input  rec_t        q_rec,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        record_kind,
	output logic [31:0] chunk_type,
	output logic [31:0] chunk_length,
	output logic        crc_match,
	output logic [31:0] image_width,
	output logic [31:0] image_height,
	output logic [7:0]  bit_depth,
	output logic [7:0]  colour_type,
	output logic [15:0] chunks_seen,
	output logic [7:0]  error_flags,
	output logic [31:0] trailing_count,
	output logic        last_of_run
);

	rec_t ent_q;
	logic chunk_pend_q;
	logic sum_pend_q;
	logic fire;
	logic free;

	assign out_valid   = chunk_pend_q || sum_pend_q;
	assign last_of_run = !(chunk_pend_q && sum_pend_q);
	assign fire        = out_valid && out_ready;
	assign free        = !out_valid || (fire && last_of_run);
	assign q_pop       = free && q_nonempty;

	// chunk record goes out before the summary of the same byte
	always_comb begin
		record_kind    = !chunk_pend_q;
		chunks_seen    = ent_q.count;
		chunk_type     = '0;
		chunk_length   = '0;
		crc_match      = 1'b0;
		image_width    = '0;
		image_height   = '0;
		bit_depth      = '0;
		colour_type    = '0;
		error_flags    = '0;
		trailing_count = '0;
		if (chunk_pend_q) begin
			chunk_type   = ent_q.ctype;
			chunk_length = ent_q.clen;
			crc_match    = ent_q.match;
		end else begin
			image_width    = ent_q.width;
			image_height   = ent_q.height;
			bit_depth      = ent_q.depth;
			colour_type    = ent_q.colour;
			error_flags    = ent_q.flags;
			trailing_count = ent_q.trail;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ent_q <= q_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_pend_q <= 1'b0;
			sum_pend_q   <= 1'b0;
		end else if (q_pop) begin
			chunk_pend_q <= q_rec.has_chunk;
			sum_pend_q   <= q_rec.has_sum;
		end else if (fire) begin
			if (chunk_pend_q) begin
				chunk_pend_q <= 1'b0;
			end else begin
				sum_pend_q <= 1'b0;
			end
		end else if (free) begin
			chunk_pend_q <= 1'b0;
			sum_pend_q   <= 1'b0;
		end
	end

endmodule

### sim/tb_top.sv
// Self-checking bench for png_chunk_stream_checker_core: random PNG files, stalls on both sides.
// Predicts chunk records and end-of-file summaries byte by byte; depends on pcsc_pkg and the RTL.
module tb_top
	import pcsc_pkg::*;
();

	localparam logic [63:0] PNG_MAGIC = 64'h89504E470D0A1A0A;
	localparam logic REC_CHUNK   = 1'b0;
	localparam logic REC_SUMMARY = 1'b1;
	localparam int ERR_SIG      = 0;
	localparam int ERR_CRC      = 1;
	localparam int ERR_TRUNC    = 2;
	localparam int ERR_ORDER    = 3;
	localparam int ERR_NO_IHDR  = 4;
	localparam int ERR_NO_IDAT  = 5;
	localparam int ERR_NO_IEND  = 6;
	localparam int ERR_TRAIL    = 7;
	localparam int RANDOM_BYTES = 1300;

	typedef struct packed {
		logic [7:0] b;
		logic       eof;
	} png_byte_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] ctype;
		logic [31:0] clen;
		logic        match;
		logic [31:0] width;
		logic [31:0] height;
		logic [7:0]  depth;
		logic [7:0]  colour;
		logic [15:0] count;
		logic [7:0]  flags;
		logic [31:0] trail;
		logic        last;
	} png_record_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        end_of_file = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        record_kind;
	logic [31:0] chunk_type;
	logic [31:0] chunk_length;
	logic        crc_match;
	logic [31:0] image_width;
	logic [31:0] image_height;
	logic [7:0]  bit_depth;
	logic [7:0]  colour_type;
	logic [15:0] chunks_seen;
	logic [7:0]  error_flags;
	logic [31:0] trailing_count;
	logic        last_of_run;

	png_byte_t   byte_feed[$];
	png_record_t expected_records[$];
	logic [7:0]  file_buf[$];
	logic [7:0]  chunk_data[$];
	int          bytes_taken = 0;
	int          stim_total = 0;
	int          fault_count = 0;
	int          hold_left = 0;
	logic        hold_armed = 1'b1;

	// predicted walker state
	phase_t      walk_ph;
	logic [31:0] field_idx;
	logic [31:0] len_acc;
	logic [31:0] type_acc;
	logic [31:0] crc_acc;
	logic [31:0] crc_field;
	logic [31:0] img_w;
	logic [31:0] img_h;
	logic [15:0] img_dc;
	logic [15:0] chunk_cnt;
	logic [31:0] trail_cnt;
	logic [63:0] chunk_byte_cnt;
	logic [31:0] pend_w;
	logic [31:0] pend_h;
	logic [15:0] pend_dc;
	logic        seen_ihdr, seen_idat, seen_iend, ihdr_first, any_chunk;
	logic        sig_bad, crc_bad, stop_sig;

	png_chunk_stream_checker_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.end_of_file(end_of_file),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.record_kind(record_kind),
		.chunk_type(chunk_type),
		.chunk_length(chunk_length),
		.crc_match(crc_match),
		.image_width(image_width),
		.image_height(image_height),
		.bit_depth(bit_depth),
		.colour_type(colour_type),
		.chunks_seen(chunks_seen),
		.error_flags(error_flags),
		.trailing_count(trailing_count),
		.last_of_run(last_of_run)
	);

	always #5 clk = ~clk;

	// Bit-serial reflected CRC-32 update.
	function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		logic fb;
		r = c;
		for (int i = 0; i < 8; i++) begin
			fb = r[0] ^ b[i];
			r = r >> 1;
			if (fb)
				r = r ^ CRC_POLY;
		end
		return r;
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(255));
	endfunction

	task automatic reset_walker();
		walk_ph = PH_SIG;
		field_idx = '0;
		len_acc = '0;
		type_acc = '0;
		crc_acc = CRC_INIT;
		crc_field = '0;
		img_w = '0;
		img_h = '0;
		img_dc = '0;
		chunk_cnt = '0;
		trail_cnt = '0;
		chunk_byte_cnt = '0;
		pend_w = '0;
		pend_h = '0;
		pend_dc = '0;
		{seen_ihdr, seen_idat, seen_iend, ihdr_first, any_chunk} = '0;
		{sig_bad, crc_bad, stop_sig} = '0;
	endtask

	task automatic add_trailing(input logic [63:0] n);
		logic [63:0] s;
		s = {32'd0, trail_cnt} + n;
		trail_cnt = (s > 64'hFFFFFFFF) ? 32'hFFFFFFFF : s[31:0];
	endtask

	// Advance the predicted walker by one accepted byte and queue what it yields.
	task automatic walk_png_byte(input logic [7:0] b, input logic eof);
		png_record_t chunk_rec;
		png_record_t sum_rec;
		logic        have_chunk;
		have_chunk = 1'b0;
		chunk_rec = '0;
		case (walk_ph)
			PH_SIG: begin
				if (b != PNG_MAGIC[63 - 8 * field_idx[2:0] -: 8])
					sig_bad = 1'b1;
				field_idx++;
				if (field_idx >= 8) begin
					field_idx = '0;
					if (sig_bad) begin
						stop_sig = 1'b1;
						walk_ph = PH_STOP;
					end else begin
						walk_ph = PH_LEN;
					end
				end
			end
			PH_LEN: begin
				len_acc = {len_acc[23:0], b};
				chunk_byte_cnt++;
				field_idx++;
				if (field_idx >= 4) begin
					field_idx = '0;
					crc_acc = CRC_INIT;
					walk_ph = PH_TYPE;
				end
			end
			PH_TYPE: begin
				type_acc = {type_acc[23:0], b};
				crc_acc = crc_step(crc_acc, b);
				chunk_byte_cnt++;
				field_idx++;
				if (field_idx >= 4) begin
					field_idx = '0;
					walk_ph = (len_acc == 0) ? PH_CRC : PH_DATA;
				end
			end
			PH_DATA: begin
				crc_acc = crc_step(crc_acc, b);
				chunk_byte_cnt++;
				if (field_idx < 4)
					pend_w = {pend_w[23:0], b};
				else if (field_idx < 8)
					pend_h = {pend_h[23:0], b};
				else if (field_idx < 10)
					pend_dc = {pend_dc[7:0], b};
				field_idx++;
				if (field_idx >= len_acc) begin
					field_idx = '0;
					walk_ph = PH_CRC;
				end
			end
			PH_CRC: begin
				crc_field = {crc_field[23:0], b};
				chunk_byte_cnt++;
				field_idx++;
				if (field_idx >= 4) begin
					chunk_rec.match = (crc_field == ~crc_acc);
					if (chunk_cnt != 16'hFFFF)
						chunk_cnt++;
					if (!any_chunk && type_acc == TYPE_IHDR)
						ihdr_first = 1'b1;
					any_chunk = 1'b1;
					if (type_acc == TYPE_IHDR) begin
						seen_ihdr = 1'b1;
						if (len_acc >= IHDR_MIN_LEN) begin
							img_w = pend_w;
							img_h = pend_h;
							img_dc = pend_dc;
						end
					end else if (type_acc == TYPE_IDAT) begin
						seen_idat = 1'b1;
					end else if (type_acc == TYPE_IEND) begin
						seen_iend = 1'b1;
					end
					chunk_rec.kind = REC_CHUNK;
					chunk_rec.ctype = type_acc;
					chunk_rec.clen = len_acc;
					chunk_rec.count = chunk_cnt;
					have_chunk = 1'b1;
					field_idx = '0;
					len_acc = '0;
					type_acc = '0;
					crc_field = '0;
					chunk_byte_cnt = '0;
					if (chunk_rec.match) begin
						walk_ph = PH_LEN;
					end else begin
						crc_bad = 1'b1;
						walk_ph = PH_STOP;
					end
				end
			end
			default: add_trailing(64'd1);
		endcase

		if (have_chunk) begin
			chunk_rec.last = !eof;
			expected_records.insert(expected_records.size(), chunk_rec);
		end
		if (eof) begin
			sum_rec = '0;
			sum_rec.kind = REC_SUMMARY;
			sum_rec.flags[ERR_SIG] = (walk_ph == PH_SIG) || stop_sig;
			sum_rec.flags[ERR_CRC] = crc_bad;
			if (walk_ph inside {PH_LEN, PH_TYPE, PH_DATA, PH_CRC}) begin
				sum_rec.flags[ERR_TRUNC] = (chunk_byte_cnt >= 12);
				add_trailing(chunk_byte_cnt);
			end
			sum_rec.flags[ERR_ORDER] = !ihdr_first;
			sum_rec.flags[ERR_NO_IHDR] = !seen_ihdr;
			sum_rec.flags[ERR_NO_IDAT] = !seen_idat;
			sum_rec.flags[ERR_NO_IEND] = !seen_iend;
			sum_rec.flags[ERR_TRAIL] = (trail_cnt != 0);
			sum_rec.width = img_w;
			sum_rec.height = img_h;
			sum_rec.depth = img_dc[15:8];
			sum_rec.colour = img_dc[7:0];
			sum_rec.count = chunk_cnt;
			sum_rec.trail = trail_cnt;
			sum_rec.last = 1'b1;
			expected_records.insert(expected_records.size(), sum_rec);
			reset_walker();
		end
	endtask

	// ---- file construction ----

	task automatic push_word(input logic [31:0] w);
		for (int i = 0; i < 4; i++)
			file_buf.insert(file_buf.size(), w[31 - 8 * i -: 8]);
	endtask

	// Corrupt the signature byte at bad_pos; a negative position keeps it intact.
	task automatic add_sig(input int bad_pos);
		logic [7:0] v;
		logic [7:0] flip;
		for (int i = 0; i < 8; i++) begin
			v = PNG_MAGIC[63 - 8 * i -: 8];
			flip = 8'($urandom_range(255, 1));
			if (i == bad_pos)
				v = v ^ flip;
			file_buf.insert(file_buf.size(), v);
		end
	endtask

	// Wrap chunk_data into a chunk of the given type, then drain it.
	task automatic add_chunk(input logic [31:0] ctype, input logic bad_crc);
		logic [31:0] c;
		c = CRC_INIT;
		push_word(chunk_data.size());
		push_word(ctype);
		for (int i = 0; i < 4; i++)
			c = crc_step(c, ctype[31 - 8 * i -: 8]);
		foreach (chunk_data[i]) begin
			c = crc_step(c, chunk_data[i]);
			file_buf.insert(file_buf.size(), chunk_data[i]);
		end
		c = ~c;
		if (bad_crc)
			c = c ^ (32'($urandom) | 32'h1);
		push_word(c);
		chunk_data.delete();
	endtask

	task automatic fill_ihdr(input int len, input logic [31:0] w, input logic [31:0] h,
			input logic [7:0] d, input logic [7:0] col);
		logic [103:0] body;
		body = {w, h, d, col, 24'($urandom)};
		for (int i = 0; i < len; i++) begin
			if (i < 13)
				chunk_data.insert(chunk_data.size(), body[103 - 8 * i -: 8]);
			else
				chunk_data.insert(chunk_data.size(), rand_byte());
		end
	endtask

	task automatic fill_random(input int len);
		repeat (len) chunk_data.insert(chunk_data.size(), rand_byte());
	endtask

	// Move the file into the feed, flagging its last byte.
	task automatic emit_file();
		foreach (file_buf[i])
			byte_feed.insert(byte_feed.size(), {file_buf[i], i == file_buf.size() - 1});
		file_buf.delete();
	endtask

	task automatic random_file();
		int pick;
		int n;
		int cut;
		logic [31:0] rtype;
		if ($urandom_range(19) == 0) begin
			// plain noise
			repeat ($urandom_range(30, 1)) file_buf.insert(file_buf.size(), rand_byte());
			emit_file();
			return;
		end
		add_sig(($urandom_range(19) == 0) ? int'($urandom_range(7)) : -1);
		if ($urandom_range(9) < 8) begin
			fill_ihdr(($urandom_range(4) == 0) ? int'($urandom_range(20)) : 13,
				$urandom, $urandom, rand_byte(), rand_byte());
			add_chunk(TYPE_IHDR, $urandom_range(19) == 0);
		end
		n = $urandom_range(4);
		repeat (n) begin
			pick = $urandom_range(19);
			fill_random($urandom_range(16));
			if (pick < 10) begin
				rtype = TYPE_IDAT;
			end else if (pick < 15) begin
				rtype = $urandom;
			end else if (pick < 17) begin
				chunk_data.delete();
				fill_ihdr($urandom_range(20), $urandom, $urandom, rand_byte(), rand_byte());
				rtype = TYPE_IHDR;
			end else begin
				rtype = TYPE_IEND;
			end
			add_chunk(rtype, $urandom_range(19) == 0);
		end
		if ($urandom_range(19) != 0)
			add_chunk(TYPE_IEND, $urandom_range(29) == 0);
		case ($urandom_range(9))
			0: begin
				cut = $urandom_range(file_buf.size(), 1);
				while (file_buf.size() > cut)
					file_buf.delete(file_buf.size() - 1);
			end
			1: repeat ($urandom_range(6, 1)) file_buf.insert(file_buf.size(), rand_byte());
			2: begin
				cut = $urandom_range(file_buf.size() - 1, 8);
				file_buf[cut] = file_buf[cut] ^ 8'($urandom_range(255, 1));
			end
			default: ;
		endcase
		emit_file();
	endtask

	task automatic build_directed();
		// one stray byte
		file_buf.insert(file_buf.size(), 8'hFF);
		emit_file();
		// file ending inside a good signature
		add_sig(-1);
		while (file_buf.size() > 3)
			file_buf.delete(file_buf.size() - 1);
		emit_file();
		// broken signature, rest is trailing
		add_sig(3);
		repeat (4) file_buf.insert(file_buf.size(), rand_byte());
		emit_file();
		// well-formed, extreme IHDR values, file ends on the IEND CRC
		add_sig(-1);
		fill_ihdr(13, 32'hFFFFFFFF, 32'h0, 8'hFF, 8'h00);
		add_chunk(TYPE_IHDR, 1'b0);
		repeat (5) begin
			chunk_data.insert(chunk_data.size(), 8'h00);
			chunk_data.insert(chunk_data.size(), 8'hFF);
		end
		add_chunk(TYPE_IDAT, 1'b0);
		add_chunk(TYPE_IEND, 1'b0);
		emit_file();
		// CRC mismatch stops the walk
		add_sig(-1);
		fill_ihdr(13, 32'h0, 32'hFFFFFFFF, 8'h00, 8'hFF);
		add_chunk(TYPE_IHDR, 1'b0);
		fill_random(4);
		add_chunk(TYPE_IDAT, 1'b1);
		add_chunk(TYPE_IEND, 1'b0);
		emit_file();
		// IHDR out of order and too short to capture
		add_sig(-1);
		fill_random(3);
		add_chunk(TYPE_IDAT, 1'b0);
		fill_ihdr(5, $urandom, $urandom, rand_byte(), rand_byte());
		add_chunk(TYPE_IHDR, 1'b0);
		add_chunk(TYPE_IEND, 1'b0);
		emit_file();
		// two IHDRs, the later one wins
		add_sig(-1);
		fill_ihdr(13, $urandom, $urandom, rand_byte(), rand_byte());
		add_chunk(TYPE_IHDR, 1'b0);
		fill_ihdr(20, $urandom, $urandom, rand_byte(), rand_byte());
		add_chunk(TYPE_IHDR, 1'b0);
		fill_random(2);
		add_chunk(TYPE_IDAT, 1'b0);
		add_chunk(TYPE_IEND, 1'b0);
		emit_file();
		// partial chunk of 11 bytes: trailing but not truncated
		add_sig(-1);
		push_word(32'd13);
		push_word(TYPE_IHDR);
		repeat (3) file_buf.insert(file_buf.size(), rand_byte());
		emit_file();
		// huge length, partial data: truncated
		add_sig(-1);
		push_word(32'hFFFFFFFF);
		push_word(TYPE_IDAT);
		repeat (6) file_buf.insert(file_buf.size(), rand_byte());
		emit_file();
		// signature alone
		add_sig(-1);
		emit_file();
		// complete file with a few stray bytes after IEND
		add_sig(-1);
		fill_ihdr(13, $urandom, $urandom, rand_byte(), rand_byte());
		add_chunk(TYPE_IHDR, 1'b0);
		fill_random(1);
		add_chunk(TYPE_IDAT, 1'b0);
		add_chunk(TYPE_IEND, 1'b0);
		repeat (2) file_buf.insert(file_buf.size(), rand_byte());
		emit_file();
	endtask

	// ---- handshake pacing ----

	function automatic int idle_phase();
		if (bytes_taken * 3 < stim_total)
			return 0;
		else if (bytes_taken * 3 < stim_total * 2)
			return 1;
		return 2;
	endfunction

	function automatic logic sender_idle();
		case (idle_phase())
			0: return $urandom_range(99) < 22;
			1: return $urandom_range(99) < 75;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic receiver_idle();
		case (idle_phase())
			0: return $urandom_range(99) < 75;
			1: return $urandom_range(99) < 22;
			default: return 1'b0;
		endcase
	endfunction

	// ---- driver ----

	always @(posedge clk or negedge arst_n) begin
		png_byte_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			data_byte <= 8'h00;
			end_of_file <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				walk_png_byte(data_byte, end_of_file);
				bytes_taken <= bytes_taken + 1;
			end
			// hold the offered byte until its transfer
			if (!in_valid || in_ready) begin
				if (byte_feed.size() != 0 && !sender_idle()) begin
					nxt = byte_feed.pop_front();
					in_valid <= 1'b1;
					data_byte <= nxt.b;
					end_of_file <= nxt.eof;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---- long receiver hold-off, once, to back the block up ----

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_armed <= 1'b1;
		end else if (hold_armed && bytes_taken >= 150) begin
			hold_left <= 400;
			hold_armed <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// ---- monitor ----

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			if (fault_count < 10)
				$display("%0t: %s mismatch, expected %h got %h", $time, name, want, got);
			fault_count++;
		end
	endtask

	task automatic check_record();
		png_record_t want;
		if (expected_records.size() == 0) begin
			if (fault_count < 10)
				$display("%0t: result with nothing expected, kind %b", $time, record_kind);
			fault_count++;
		end else begin
			want = expected_records.pop_front();
			check_field("record_kind", 32'(want.kind), 32'(record_kind));
			check_field("chunk_type", want.ctype, chunk_type);
			check_field("chunk_length", want.clen, chunk_length);
			check_field("crc_match", 32'(want.match), 32'(crc_match));
			check_field("image_width", want.width, image_width);
			check_field("image_height", want.height, image_height);
			check_field("bit_depth", 32'(want.depth), 32'(bit_depth));
			check_field("colour_type", 32'(want.colour), 32'(colour_type));
			check_field("chunks_seen", 32'(want.count), 32'(chunks_seen));
			check_field("error_flags", 32'(want.flags), 32'(error_flags));
			check_field("trailing_count", want.trail, trailing_count);
			check_field("last_of_run", 32'(want.last), 32'(last_of_run));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				check_record();
			out_ready <= (hold_left == 0) && !receiver_idle();
		end
	end

	// ---- sequence ----

	initial begin
		int directed_bytes;
		reset_walker();
		build_directed();
		directed_bytes = byte_feed.size();
		while (byte_feed.size() < directed_bytes + RANDOM_BYTES)
			random_file();
		stim_total = byte_feed.size();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		while (bytes_taken != stim_total)
			@(posedge clk);
		while (expected_records.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (fault_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
